// ===== rtl/core/hrp_pkg.sv =====
`default_nettype none
package hrp_pkg;
  localparam int MaxBins = 16384;
  localparam int AddrBits = 14;
  localparam logic [16:0] Q16One = 17'd65536;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpFinal = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StKeepZero = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  localparam logic RegKeepFraction = 1'b0;
  localparam logic RegOrderMode = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] bin_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pruned_value;
    logic last_bin;
    logic [31:0] threshold_value;
    logic [14:0] nonzero_count;
    logic [14:0] keep_rank;
    logic [1:0] status;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/histogram_rank_prune.sv =====
`default_nettype none
// Histogram rank pruning block.
// Items arrive on in_valid/in_ready carrying an op and a bin value; results
// leave on out_valid/out_ready. A load item writes the next bin into a
// 16384 entry memory and gives no result; it stays in the idle state, so
// loads can follow each other with no gap. A read item returns the next
// loaded bin, if one is left, pruned against the threshold.
// A finalize item computes the keep count with one multiply and, unless it is
// zero, runs a binary search for the threshold over the count range: up to
// 32 search steps, each a full sweep of the loaded bins through the memory
// read port. The sweep shares one compare and count unit.
// One item is worked on at a time; in_ready is low while an item is busy or
// while a result waits in the output register. When the receiver stalls, the
// result holds in that register until taken.
// Reset (synchronous, active high) clears counts, flags, threshold and the
// registers (keep_fraction to 1.0, order_mode to descending). The bin memory
// is not cleared; only written entries are ever used.
module histogram_rank_prune (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hrp_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hrp_pkg::out_item_t    out_item,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [16:0]      cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_RDOUT = 3'd2;
  localparam logic [2:0] S_KEEP = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_RDWAIT = 3'd7;

  logic [31:0] mem [hrp_pkg::MaxBins];
  logic [31:0] rdata;
  logic [hrp_pkg::AddrBits-1:0] raddr;

  logic [2:0] state;
  logic [16:0] keep_fraction;
  logic order_mode;
  logic [14:0] loaded_count, nonzero_total, read_pointer, keep, rank;
  logic [31:0] threshold_reg, lo, hi, mid;
  logic overflow_flag, prune_enable;
  logic [14:0] sweep_idx, hits;
  logic sweep_valid;
  logic [31:0] prod;
  logic [31:0] rd_pruned;
  hrp_pkg::out_item_t out_reg;
  logic out_full;

  assign in_ready = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;
  assign out_item = out_reg;
  assign mid = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_item.op == hrp_pkg::OpLoad &&
        loaded_count < 15'(hrp_pkg::MaxBins)) begin
      mem[loaded_count[hrp_pkg::AddrBits-1:0]] <= in_item.bin_count;
    end
    rdata <= mem[raddr];
  end

  // The read pointer stays on the address until the read result is built.
  always_comb begin
    raddr = sweep_idx[hrp_pkg::AddrBits-1:0];
    if (state == S_IDLE || state == S_RD || state == S_RDWAIT) begin
      raddr = read_pointer[hrp_pkg::AddrBits-1:0];
    end
  end

  always_comb begin
    rd_pruned = rdata;
    if (prune_enable) begin
      if (order_mode) begin
        if (rdata >= threshold_reg) rd_pruned = '0;
      end else if (rdata != 32'd0 && rdata <= threshold_reg) begin
        rd_pruned = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      keep_fraction <= hrp_pkg::Q16One;
      order_mode <= 1'b0;
      loaded_count <= '0;
      nonzero_total <= '0;
      read_pointer <= '0;
      threshold_reg <= '0;
      overflow_flag <= 1'b0;
      prune_enable <= 1'b0;
      out_full <= 1'b0;
      sweep_idx <= '0;
      sweep_valid <= 1'b0;
      hits <= '0;
    end else begin
      if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == hrp_pkg::RegKeepFraction) begin
          keep_fraction <= cfg_data;
        end else begin
          order_mode <= cfg_data[0];
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            case (in_item.op)
              hrp_pkg::OpLoad: begin
                if (loaded_count < 15'(hrp_pkg::MaxBins)) begin
                  loaded_count <= loaded_count + 15'd1;
                  if (in_item.bin_count != 32'd0) begin
                    nonzero_total <= nonzero_total + 15'd1;
                  end
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              hrp_pkg::OpFinal: begin
                // Fraction saturates at 1.0; keep never exceeds the total.
                prod <= 32'(nonzero_total) *
                        32'((keep_fraction > hrp_pkg::Q16One) ?
                            hrp_pkg::Q16One : keep_fraction);
                state <= S_KEEP;
              end
              hrp_pkg::OpRead: begin
                if (read_pointer < loaded_count) begin
                  state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: state <= S_RDWAIT;
        S_RDWAIT: state <= S_RDOUT;
        S_RDOUT: begin
          out_reg <= '{pruned_value: rd_pruned,
                       last_bin: (read_pointer + 15'd1 == loaded_count),
                       threshold_value: 32'd0,
                       nonzero_count: 15'd0,
                       keep_rank: 15'd0,
                       status: hrp_pkg::StOk};
          read_pointer <= read_pointer + 15'd1;
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        S_KEEP: begin
          keep <= prod[30:16];
          rank <= order_mode ? prod[30:16] : nonzero_total - prod[30:16] + 15'd1;
          lo <= 32'd1;
          hi <= 32'hFFFF_FFFF;
          sweep_idx <= '0;
          sweep_valid <= 1'b0;
          hits <= '0;
          if (prod[30:16] == 15'd0) begin
            threshold_reg <= '0;
            prune_enable <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // Count nonzero bins at or below mid, one bin per cycle.
          if (lo >= hi) begin
            threshold_reg <= lo;
            prune_enable <= 1'b1;
            state <= S_DONE;
          end else begin
            sweep_valid <= sweep_idx < loaded_count;
            if (sweep_idx < loaded_count) sweep_idx <= sweep_idx + 15'd1;
            if (sweep_valid && rdata != 32'd0 && rdata <= mid) begin
              hits <= hits + 15'd1;
            end
            if (!sweep_valid && sweep_idx >= loaded_count) begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (hits >= rank) hi <= mid;
          else lo <= mid + 32'd1;
          hits <= '0;
          sweep_idx <= '0;
          sweep_valid <= 1'b0;
          state <= S_SWEEP;
        end
        S_DONE: begin
          read_pointer <= '0;
          out_reg <= '{pruned_value: 32'd0,
                       last_bin: 1'b0,
                       threshold_value: threshold_reg,
                       nonzero_count: nonzero_total,
                       keep_rank: keep,
                       status: overflow_flag ? hrp_pkg::StOverflow :
                               (keep == 15'd0 ? hrp_pkg::StKeepZero : hrp_pkg::StOk)};
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/hrp_checker.sv =====
`default_nettype none
module hrp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire hrp_pkg::out_item_t out_item
);
  // A result is never shown while a new item is being taken.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("ready with result pending");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed under stall");
  // Reset leaves no result.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  // A read result marked as the last bin never carries a status.
  a_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_bin |-> out_item.status == hrp_pkg::StOk)
    else $error("status on read");
endmodule
bind histogram_rank_prune hrp_checker u_hrp_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item));
`default_nettype wire

// ===== test/histogram_rank_prune_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module histogram_rank_prune_tb;
  // Cycles with no accepted item before the run is stopped; the longest
  // quiet stretch of a correct run is the long receiver hold.
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hrp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hrp_pkg::out_item_t out_item;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  histogram_rank_prune dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's state, kept by the predictor.
  logic [31:0] shadow_bins [hrp_pkg::MaxBins];
  int unsigned shadow_loaded;
  int unsigned shadow_nonzero;
  logic [31:0] shadow_threshold;
  int unsigned shadow_rd_ptr;
  bit shadow_overflow;
  bit shadow_prune;
  logic [16:0] shadow_fraction;
  bit shadow_ascending;

  hrp_pkg::out_item_t expected_results [$];
  int errors = 0;
  bit hold_receiver = 1'b0;
  bit receiver_random = 1'b1;

  // Nonzero bins at or below the given count.
  function automatic int unsigned bins_at_most(logic [31:0] t);
    int unsigned n = 0;
    for (int unsigned i = 0; i < shadow_loaded; i++)
      if (shadow_bins[i] != 0 && shadow_bins[i] <= t) n++;
    return n;
  endfunction

  // Smallest count whose rank reaches the requested position.
  function automatic logic [31:0] rank_threshold(int unsigned rank);
    longint unsigned lo = 1, hi = 64'hFFFF_FFFF, mid;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (bins_at_most(mid[31:0]) >= rank) hi = mid;
      else lo = mid + 1;
    end
    return lo[31:0];
  endfunction

  // Advances the shadow state by one accepted item and queues any result.
  task automatic predict_item(hrp_pkg::in_item_t it);
    hrp_pkg::out_item_t r;
    longint unsigned frac, keep;
    int unsigned rank;
    logic [31:0] v;
    r = '0;
    case (it.op)
      hrp_pkg::OpLoad: begin
        if (shadow_loaded < hrp_pkg::MaxBins) begin
          shadow_bins[shadow_loaded] = it.bin_count;
          shadow_loaded++;
          if (it.bin_count != 0) shadow_nonzero++;
        end else begin
          shadow_overflow = 1'b1;
        end
      end
      hrp_pkg::OpFinal: begin
        frac = (shadow_fraction > hrp_pkg::Q16One) ? hrp_pkg::Q16One : shadow_fraction;
        keep = (longint'(shadow_nonzero) * frac) >> 16;
        if (keep > shadow_nonzero) keep = shadow_nonzero;
        if (keep == 0) begin
          shadow_threshold = '0;
          shadow_prune = 1'b0;
        end else begin
          rank = shadow_ascending ? 32'(keep) : shadow_nonzero - 32'(keep) + 1;
          shadow_threshold = rank_threshold(rank);
          shadow_prune = 1'b1;
        end
        shadow_rd_ptr = 0;
        r.threshold_value = shadow_threshold;
        r.nonzero_count = shadow_nonzero[14:0];
        r.keep_rank = keep[14:0];
        r.status = shadow_overflow ? hrp_pkg::StOverflow :
                   (keep == 0 ? hrp_pkg::StKeepZero : hrp_pkg::StOk);
        expected_results.push_back(r);
      end
      hrp_pkg::OpRead: begin
        if (shadow_rd_ptr < shadow_loaded) begin
          v = shadow_bins[shadow_rd_ptr];
          if (shadow_prune) begin
            if (shadow_ascending) begin
              if (v >= shadow_threshold) v = '0;
            end else if (v != 0 && v <= shadow_threshold) begin
              v = '0;
            end
          end
          r.pruned_value = v;
          r.last_bin = (shadow_rd_ptr + 1 == shadow_loaded);
          shadow_rd_ptr++;
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Offers one item after a random gap and waits until it is accepted.
  // Valid stays high after acceptance until the next call or a drain
  // lowers it, so each signal is driven once per edge.
  task automatic send_item(logic [1:0] op, logic [31:0] value);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    cfg_write <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= hrp_pkg::in_item_t'{op: op, bin_count: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(hrp_pkg::in_item_t'{op: op, bin_count: value});
  endtask

  // Waits for every expected result, then for the block to settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_write <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // The write enable is lowered by the next send or drain.
  task automatic write_register(logic index, logic [16:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index == hrp_pkg::RegKeepFraction) shadow_fraction = value;
    else shadow_ascending = value[0];
  endtask

  // Random count, often small so that ties and zeros are common.
  function automatic logic [31:0] random_count();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(1, 8);
      2: return 32'hFFFF_FFFF;
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Loads a histogram, finalizes it and reads every bin plus one past the end.
  task automatic run_histogram(int unsigned n_bins);
    for (int unsigned i = 0; i < n_bins; i++) send_item(hrp_pkg::OpLoad, random_count());
    send_item(hrp_pkg::OpFinal, $urandom);
    for (int unsigned i = 0; i <= n_bins; i++) send_item(hrp_pkg::OpRead, $urandom);
  endtask

  // Directed: extremes of the counts, reads before finalize, the unused op
  // code, reads with nothing loaded and the keep count of zero.
  task automatic test_directed();
    send_item(hrp_pkg::OpRead, 32'h0);
    send_item(hrp_pkg::OpFinal, 32'h0);
    send_item(hrp_pkg::OpUnused, 32'hFFFF_FFFF);
    send_item(hrp_pkg::OpLoad, 32'h0);
    send_item(hrp_pkg::OpLoad, 32'hFFFF_FFFF);
    send_item(hrp_pkg::OpLoad, 32'h1);
    send_item(hrp_pkg::OpLoad, 32'h8000_0000);
    send_item(hrp_pkg::OpLoad, 32'h1);
    send_item(hrp_pkg::OpRead, 32'h0);
    send_item(hrp_pkg::OpRead, 32'h0);
    send_item(hrp_pkg::OpFinal, 32'h0);
    for (int i = 0; i < 6; i++) send_item(hrp_pkg::OpRead, 32'hFFFF_FFFF);
    drain_results();
    write_register(hrp_pkg::RegOrderMode, 17'd1);
    write_register(hrp_pkg::RegKeepFraction, 17'd0);
    send_item(hrp_pkg::OpFinal, 32'h0);
    send_item(hrp_pkg::OpRead, 32'h0);
    drain_results();
    write_register(hrp_pkg::RegKeepFraction, 17'h1FFFF);
    send_item(hrp_pkg::OpFinal, 32'h0);
    send_item(hrp_pkg::OpRead, 32'h0);
    send_item(hrp_pkg::OpRead, 32'h0);
    // Loads after finalize keep the old threshold until the next finalize.
    send_item(hrp_pkg::OpLoad, 32'h7);
    drain_results();
  endtask

  // Random histograms over several register settings.
  task automatic test_random_settings();
    logic [16:0] fractions [6] = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'h1FFFF};
    for (int s = 0; s < 10; s++) begin
      write_register(hrp_pkg::RegKeepFraction,
                     s < 6 ? fractions[s] : 17'($urandom_range(0, 17'h1FFFF)));
      write_register(hrp_pkg::RegOrderMode, {16'd0, s[0]});
      run_histogram($urandom_range(1, 14));
      // Some noise: stray reads and unused op codes between histograms.
      repeat ($urandom_range(0, 3)) send_item(2'($urandom_range(2, 3)), $urandom);
      drain_results();
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    receiver_random = 1'b0;
    hold_receiver = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_receiver = 1'b0;
      end
      run_histogram(10);
    join
    receiver_random = 1'b1;
    drain_results();
  endtask

  // Receiver: waits a drawn number of cycles for each item, or is held off.
  int recv_wait = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) recv_wait = receiver_random ? $urandom_range(0, 12) : 0;
    if (rst || hold_receiver) begin
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      out_ready <= 1'b0;
      recv_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_item);
        errors++;
      end else if (out_item !== expected_results[0]) begin
        $display("%0t: mismatch expected %p actual %p", $realtime,
                 expected_results[0], out_item);
        errors++;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    shadow_loaded = 0;
    shadow_nonzero = 0;
    shadow_threshold = '0;
    shadow_rd_ptr = 0;
    shadow_overflow = 1'b0;
    shadow_prune = 1'b0;
    shadow_fraction = hrp_pkg::Q16One;
    shadow_ascending = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    test_random_settings();
    drain_results();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
